// File: rtl/rqch_pkg.sv
// Shared types and constants of the ray quad closest-hit block.
package rqch_pkg;

    localparam int RQCH_MAX_FACES = 65536;
    localparam int RQCH_FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int EDGE_W  = 33;
    localparam int XP_W    = 67;
    localparam int ACC_W   = 104;
    localparam int DVD_W   = 128;
    localparam int OP_W    = 35;
    localparam int FACE_W  = 16;

    localparam logic [COORD_W-1:0] DIR_Z_RESET   = 32'd65536;
    localparam logic [15:0]        EPS_RESET     = 16'd1;
    localparam logic [30:0]        MAX_DIST_RESET = 31'd655360000;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_ORIGIN_Z    = 3'd2,
        REG_DIRECTION_X = 3'd3,
        REG_DIRECTION_Y = 3'd4,
        REG_DIRECTION_Z = 3'd5,
        REG_DET_EPSILON = 3'd6,
        REG_MAX_DIST    = 3'd7
    } rqch_reg_t;

    typedef struct packed {
        logic [2:0][EDGE_W-1:0] e1;
        logic [2:0][EDGE_W-1:0] e2;
        logic [2:0][EDGE_W-1:0] tv;
        logic [FACE_W-1:0]      face;
        logic                   last;
        logic                   skip;
    } rqch_tri_t;

    typedef struct packed {
        logic [COORD_W-1:0] hit_distance;
        logic [FACE_W-1:0]  hit_face;
        logic               hit_found;
    } rqch_res_t;

endpackage

// File: rtl/rqch_front.sv
// Input stage: accepts triangles, forms edges and flags faces out of range.
module rqch_front #(
    parameter int MAX_FACES = rqch_pkg::RQCH_MAX_FACES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [8:0][rqch_pkg::COORD_W-1:0]     verts,
    input  logic [rqch_pkg::FACE_W-1:0]           face,
    input  logic                                  last,
    input  logic [2:0][rqch_pkg::COORD_W-1:0]     origin,
    output logic                                  push,
    input  logic                                  q_full,
    output rqch_pkg::rqch_tri_t                   push_data
);
    import rqch_pkg::*;

    logic      fv_reg;
    rqch_tri_t fd_reg;
    rqch_tri_t fd_next;

    assign push     = fv_reg && !q_full;
    assign in_ready = !fv_reg || !q_full;
    assign push_data = fd_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fd_next.e1[i] = {verts[3+i][31], verts[3+i]} - {verts[i][31], verts[i]};
            fd_next.e2[i] = {verts[6+i][31], verts[6+i]} - {verts[i][31], verts[i]};
            fd_next.tv[i] = {origin[i][31], origin[i]} - {verts[i][31], verts[i]};
        end
        fd_next.face = face;
        fd_next.last = last;
        fd_next.skip = !({1'b0, face} < (FACE_W+1)'(MAX_FACES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            fv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fd_reg <= fd_next;
        end
    end

endmodule

// File: rtl/rqch_queue.sv
// Two-entry queue between the input stage and the intersection engine.
module rqch_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rqch_pkg::rqch_tri_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output rqch_pkg::rqch_tri_t head_data
);
    import rqch_pkg::*;

    rqch_tri_t   mem_reg [2];
    logic        wr_reg;
    logic        rd_reg;
    logic [1:0]  cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/rqch_back.sv
// Intersection engine: shared multiplier, bound tests, divider, best-hit tracking.
module rqch_back #(
    parameter int FRAC_BITS = rqch_pkg::RQCH_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  rqch_pkg::rqch_tri_t               q_data,
    output logic                              q_pop,
    input  logic [2:0][rqch_pkg::COORD_W-1:0] dir,
    input  logic [15:0]                       det_epsilon,
    input  logic [30:0]                       max_distance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rqch_pkg::rqch_res_t               out_res
);
    import rqch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DRAIN, S_NORM, S_TEST, S_DIV, S_SAT, S_UPD, S_FIN
    } state_t;

    localparam logic [2:0] G_PV  = 3'd0;
    localparam logic [2:0] G_QV  = 3'd1;
    localparam logic [2:0] G_DET = 3'd2;
    localparam logic [2:0] G_UN  = 3'd3;
    localparam logic [2:0] G_VN  = 3'd4;
    localparam logic [2:0] G_TN  = 3'd5;

    function automatic logic [1:0] nx3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic signed [OP_W-1:0] ext_e(input logic [EDGE_W-1:0] e);
        return {{(OP_W-EDGE_W){e[EDGE_W-1]}}, e};
    endfunction

    function automatic logic signed [OP_W-1:0] ext_d(input logic [COORD_W-1:0] d);
        return {{(OP_W-COORD_W){d[COORD_W-1]}}, d};
    endfunction

    function automatic logic signed [OP_W-1:0] xp_part(input logic [XP_W-1:0] p,
                                                       input logic hi);
        return hi ? {{(OP_W-(XP_W-34)){p[XP_W-1]}}, p[XP_W-1:34]} : {1'b0, p[33:0]};
    endfunction

    state_t state_reg;
    logic [2:0] grp_reg;
    logic [1:0] idx_reg;
    logic       half_reg;

    logic [2:0][XP_W-1:0] pv_reg;
    logic [2:0][XP_W-1:0] qv_reg;
    logic [ACC_W-1:0] det_reg, un_reg, vn_reg, tn_reg, acc_reg, rem_reg;
    logic [31:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        tneg_reg;
    logic [31:0] dist_reg;

    logic signed [2*OP_W-1:0] prod_reg;
    logic       pv_v_reg, pneg_reg, phi_reg, pend_reg;
    logic [2:0] pgrp_reg;
    logic [1:0] pidx_reg;

    logic        any_hit_reg;
    logic [15:0] best_face_reg;
    logic [31:0] best_dist_reg;
    logic        out_valid_reg;
    rqch_res_t   out_res_reg;

    logic signed [OP_W-1:0] opa, opb;
    logic op_neg, op_hi, op_end;
    logic [1:0] j1, j2;
    logic [ACC_W-1:0] pext, psh, acc_sum;

    always_comb
    begin
        j1 = nx3(idx_reg);
        j2 = nx3(j1);
        op_neg = 1'b0;
        op_hi  = 1'b0;
        op_end = half_reg && (idx_reg == 2'd2);
        unique case (grp_reg)
            G_PV:
            begin
                opa = ext_d(dir[half_reg ? j2 : j1]);
                opb = ext_e(q_data.e2[half_reg ? j1 : j2]);
                op_neg = half_reg;
                op_end = half_reg;
            end
            G_QV:
            begin
                opa = ext_e(q_data.tv[half_reg ? j2 : j1]);
                opb = ext_e(q_data.e1[half_reg ? j1 : j2]);
                op_neg = half_reg;
                op_end = half_reg;
            end
            G_DET:
            begin
                opa = ext_e(q_data.e1[idx_reg]);
                opb = xp_part(pv_reg[idx_reg], half_reg);
                op_hi = half_reg;
            end
            G_UN:
            begin
                opa = ext_e(q_data.tv[idx_reg]);
                opb = xp_part(pv_reg[idx_reg], half_reg);
                op_hi = half_reg;
            end
            G_VN:
            begin
                opa = ext_d(dir[idx_reg]);
                opb = xp_part(qv_reg[idx_reg], half_reg);
                op_hi = half_reg;
            end
            default:
            begin
                opa = ext_e(q_data.e2[idx_reg]);
                opb = xp_part(qv_reg[idx_reg], half_reg);
                op_hi = half_reg;
            end
        endcase
    end

    always_comb
    begin
        pext    = {{(ACC_W-2*OP_W){prod_reg[2*OP_W-1]}}, prod_reg};
        psh     = phi_reg ? (pext << 34) : pext;
        acc_sum = pneg_reg ? (acc_reg - psh) : (acc_reg + psh);
    end

    // bound tests on the sign-normalized numerators
    logic [ACC_W-1:0] eps, mag, uv_sum;
    logic [DVD_W-1:0] dvd;
    logic             pass, ovf;
    logic [ACC_W:0]   rem2;
    logic             qbit;
    logic [31:0]      bound;
    logic [31:0]      sat_dist;

    always_comb
    begin
        eps    = ACC_W'(det_epsilon) << (2*FRAC_BITS);
        uv_sum = un_reg + vn_reg;
        pass   = (det_reg != '0) && !(det_reg < eps)
                 && !un_reg[ACC_W-1] && !($signed(det_reg) < $signed(un_reg))
                 && !vn_reg[ACC_W-1] && !($signed(det_reg) < $signed(uv_sum));
        mag    = tn_reg[ACC_W-1] ? (ACC_W'(0) - tn_reg) : tn_reg;
        dvd    = DVD_W'(mag) << FRAC_BITS;
        ovf    = !(ACC_W'(dvd[DVD_W-1:32]) < det_reg);
        rem2   = {rem_reg, quo_reg[31]};
        qbit   = !(rem2 < {1'b0, det_reg});
        bound  = any_hit_reg ? best_dist_reg : {1'b0, max_distance};
        if (tneg_reg)
            sat_dist = (quo_reg > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo_reg);
        else
            sat_dist = (quo_reg > 32'h7fff_ffff) ? 32'h7fff_ffff : quo_reg;
    end

    logic emit_ok;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == S_FIN) && (!q_data.last || emit_ok);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grp_reg       <= G_PV;
            idx_reg       <= 2'd0;
            half_reg      <= 1'b0;
            pv_v_reg      <= 1'b0;
            any_hit_reg   <= 1'b0;
            best_face_reg <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            pv_v_reg <= (state_reg == S_MUL);
            if (q_pop && q_data.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pv_v_reg)
            begin
                acc_reg <= pend_reg ? '0 : acc_sum;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    grp_reg  <= G_PV;
                    idx_reg  <= 2'd0;
                    half_reg <= 1'b0;
                    if (q_valid)
                    begin
                        state_reg <= q_data.skip ? S_FIN : S_MUL;
                    end
                end
                S_MUL:
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        idx_reg <= nx3(idx_reg);
                        if (idx_reg == 2'd2)
                        begin
                            grp_reg <= grp_reg + 3'd1;
                            if (grp_reg == G_TN)
                            begin
                                state_reg <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN: state_reg <= S_NORM;
                S_NORM:  state_reg <= S_TEST;
                S_TEST:
                begin
                    if (!pass)
                        state_reg <= S_FIN;
                    else if (ovf)
                        state_reg <= S_UPD;
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT: state_reg <= S_UPD;
                S_UPD:
                begin
                    if ($signed(dist_reg) < $signed(bound))
                    begin
                        any_hit_reg   <= 1'b1;
                        best_face_reg <= q_data.face;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (q_pop)
                    begin
                        state_reg <= S_IDLE;
                        if (q_data.last)
                        begin
                            any_hit_reg   <= 1'b0;
                            best_face_reg <= '0;
                            out_res_reg.hit_found    <= any_hit_reg;
                            out_res_reg.hit_face     <= best_face_reg;
                            out_res_reg.hit_distance <= any_hit_reg ? best_dist_reg : 32'd0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        pneg_reg <= op_neg;
        phi_reg  <= op_hi;
        pend_reg <= op_end;
        pgrp_reg <= grp_reg;
        pidx_reg <= idx_reg;
        if (pv_v_reg && pend_reg)
        begin
            unique case (pgrp_reg)
                G_PV:    pv_reg[pidx_reg] <= acc_sum[XP_W-1:0];
                G_QV:    qv_reg[pidx_reg] <= acc_sum[XP_W-1:0];
                G_DET:   det_reg <= acc_sum;
                G_UN:    un_reg  <= acc_sum;
                G_VN:    vn_reg  <= acc_sum;
                default: tn_reg  <= acc_sum;
            endcase
        end
        // flip signs so the determinant is nonnegative
        if (state_reg == S_NORM && det_reg[ACC_W-1])
        begin
            det_reg <= ACC_W'(0) - det_reg;
            un_reg  <= ACC_W'(0) - un_reg;
            vn_reg  <= ACC_W'(0) - vn_reg;
            tn_reg  <= ACC_W'(0) - tn_reg;
        end
        if (state_reg == S_TEST)
        begin
            tneg_reg <= tn_reg[ACC_W-1];
            rem_reg  <= ACC_W'(dvd[DVD_W-1:32]);
            quo_reg  <= dvd[31:0];
            cnt_reg  <= 5'd0;
            dist_reg <= tn_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= qbit ? ACC_W'(rem2 - {1'b0, det_reg}) : ACC_W'(rem2);
            quo_reg <= {quo_reg[30:0], qbit};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (state_reg == S_SAT)
        begin
            dist_reg <= sat_dist;
        end
        if (state_reg == S_UPD && $signed(dist_reg) < $signed(bound))
        begin
            best_dist_reg <= dist_reg;
        end
    end

    a_face_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !any_hit_reg |-> (best_face_reg == '0))
        else $error("best face set without a recorded hit");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < det_reg))
        else $error("divider remainder not below determinant");

    a_det_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> !det_reg[ACC_W-1])
        else $error("determinant negative after normalization");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_data.last) |=> (out_valid_reg && !any_hit_reg))
        else $error("last triangle did not emit and clear");

endmodule

// File: rtl/ray_quad_closest_hit.sv
// Top level of the ray quad closest-hit block: config registers and stream ports.
//
//  channel   dir  fields (low bit up)                          handshake
//  s_*       in   tdata: ax ay az bx by bz cx cy cz face_id   tvalid/tready, tlast=last_triangle
//  m_*       out  tdata: hit_found hit_face hit_distance pad   tvalid/tready
//  cfg_*     in   index 0..7, data up to 32 bits               cfg_we, no wait
//
// An intersected triangle passes through the one shared 35x35 multiplier, the bound
// tests and the radix-2 divider.
// A triangle whose face is out of range skips the multiplier, tests and divider.
// Reset clears control state only; the input queue hides input stalls, the output
// register hides output stalls until the next last triangle needs it.
module ray_quad_closest_hit #(
    parameter int MAX_FACES = rqch_pkg::RQCH_MAX_FACES,
    parameter int FRAC_BITS = rqch_pkg::RQCH_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [303:0] s_tdata,   // ax ay az bx by bz cx cy cz (32 each), face_id (16)
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // hit_found (1), hit_face (16), hit_distance (32), zeros
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import rqch_pkg::*;

    logic [2:0][COORD_W-1:0] origin_reg;
    logic [2:0][COORD_W-1:0] dir_reg;
    logic [15:0]             eps_reg;
    logic [30:0]             max_dist_reg;

    logic [8:0][COORD_W-1:0] verts;
    logic       push, q_full, q_valid, q_pop;
    rqch_tri_t  push_data, q_data;
    rqch_res_t  res;

    assign verts = s_tdata[287:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg   <= '0;
            dir_reg      <= {DIR_Z_RESET, 32'd0, 32'd0};
            eps_reg      <= EPS_RESET;
            max_dist_reg <= MAX_DIST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rqch_reg_t'(cfg_index))
                REG_ORIGIN_X:    origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:    origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:    origin_reg[2] <= cfg_data;
                REG_DIRECTION_X: dir_reg[0]    <= cfg_data;
                REG_DIRECTION_Y: dir_reg[1]    <= cfg_data;
                REG_DIRECTION_Z: dir_reg[2]    <= cfg_data;
                REG_DET_EPSILON: eps_reg       <= cfg_data[15:0];
                REG_MAX_DIST:    max_dist_reg  <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    rqch_front #(.MAX_FACES(MAX_FACES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .verts     (verts),
        .face      (s_tdata[303:288]),
        .last      (s_tlast),
        .origin    (origin_reg),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    rqch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    rqch_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .dir          (dir_reg),
        .det_epsilon  (eps_reg),
        .max_distance (max_dist_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (res)
    );

    assign m_tdata = {7'd0, res.hit_distance, res.hit_face, res.hit_found};

endmodule
